@@ rtl/core/pbkdf_pkg.sv @@
package pbkdf_pkg;

  localparam int CHAR_W  = 8;
  localparam int ITER_W  = 20;
  localparam int ACCUM_W = 24;

  typedef struct packed {
    logic              byte_valid;
    logic [CHAR_W-1:0] byte_value;
    logic              byte_field;
    logic              done_res;
    logic              well_formed;
    logic              prefix_seen;
    logic [ITER_W-1:0] iterations;
  } pbkdf_res_t;

endpackage

@@ rtl/core/pbkdf2_hash_string_validator.sv @@
// An accepted request is held in the input stage; its result then enters a two-entry queue.
// Throughput: one character per cycle while that queue has room; it decouples output stalls.
// Characters that complete no hex pair and are not last give no result.
// Reset (rst, synchronous, active high) clears the parser state, the input stage and the queue.
// Parser state also clears after each last character, so the next request starts a new string.
module pbkdf2_hash_string_validator
  import pbkdf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_in
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [0] byte_valid, [8:1] byte_value, [9] well_formed,
                                      // [10] prefix_seen, [30:11] iterations, [31] zero
  output logic        m_axis_tuser,   // [0] byte_field
  output logic        m_axis_tlast
);

  logic              in_valid;
  logic [CHAR_W-1:0] in_char;
  logic              in_last;
  logic              step;
  logic              res_push;
  pbkdf_res_t        res;
  pbkdf_res_t        head;
  logic              q_full;
  logic              q_not_empty;

  assign step          = in_valid && !q_full;
  assign s_axis_tready = !in_valid || !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid <= 1'b1;
    end else if (step) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_char <= s_axis_tdata;
      in_last <= s_axis_tlast;
    end
  end

  pbkdf_parse u_parse (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .char_in  (in_char),
    .is_last  (in_last),
    .res_push (res_push),
    .res      (res)
  );

  pbkdf_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (res_push),
    .push_data (res),
    .pop       (m_axis_tvalid && m_axis_tready),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (head)
  );

  assign m_axis_tvalid = q_not_empty;
  assign m_axis_tdata  = {1'b0, head.iterations, head.prefix_seen, head.well_formed,
                          head.byte_value, head.byte_valid};
  assign m_axis_tuser  = head.byte_field;
  assign m_axis_tlast  = head.done_res;

endmodule

@@ rtl/core/pbkdf_parse.sv @@
module pbkdf_parse
  import pbkdf_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [CHAR_W-1:0] char_in,
  input  logic              is_last,
  output logic              res_push,
  output pbkdf_res_t        res
);

  localparam logic [2:0] PH_PREFIX = 3'd0;
  localparam logic [2:0] PH_ITER   = 3'd1;
  localparam logic [2:0] PH_SALT   = 3'd2;
  localparam logic [2:0] PH_HASH   = 3'd3;

  localparam int                    PREFIX_LEN = 14;
  localparam logic [8*PREFIX_LEN-1:0] PREFIX   = "pbkdf2-sha256$";
  localparam logic [3:0]            PREFIX_LAST = 4'(PREFIX_LEN - 1);
  localparam logic [3:0]            MAX_DIGITS  = 4'd7;
  localparam logic [ACCUM_W-1:0]    MAX_ITER    = 24'd1000000;
  localparam logic [CHAR_W-1:0]     FIELD_SEP   = 8'h24;

  logic [2:0]         phase;
  logic [3:0]         prefix_pos;
  logic [3:0]         digit_count;
  logic [ACCUM_W-1:0] iter_accum;
  logic [3:0]         high_nibble;
  logic               nibble_pending;
  logic               salt_nonempty;
  logic               hash_nonempty;
  logic               failed;

  logic [2:0]         phase_next;
  logic [3:0]         prefix_pos_next;
  logic [3:0]         digit_count_next;
  logic [ACCUM_W-1:0] iter_accum_next;
  logic [3:0]         high_nibble_next;
  logic               nibble_pending_next;
  logic               salt_nonempty_next;
  logic               hash_nonempty_next;
  logic               failed_next;

  logic [3:0]        pchar_idx;
  logic [7:0]        pchar;
  logic [4:0]        hex_val;
  logic              bvalid;
  logic [CHAR_W-1:0] bval;
  logic              bfield;
  logic              ok;

  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    v = 5'd16;
    if (c inside {[8'h30:8'h39]}) v = {1'b0, c[3:0]};
    else if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) v = 5'(c[2:0]) + 5'd9;
    return v;
  endfunction

  assign pchar_idx = PREFIX_LAST - prefix_pos;
  assign pchar     = PREFIX[{pchar_idx, 3'b000} +: 8];
  assign hex_val   = hex_value(char_in);

  always_comb begin
    phase_next          = phase;
    prefix_pos_next     = prefix_pos;
    digit_count_next    = digit_count;
    iter_accum_next     = iter_accum;
    high_nibble_next    = high_nibble;
    nibble_pending_next = nibble_pending;
    salt_nonempty_next  = salt_nonempty;
    hash_nonempty_next  = hash_nonempty;
    failed_next         = failed;
    bvalid              = 1'b0;
    bval                = '0;
    bfield              = 1'b0;
    if (!failed) begin
      case (phase)
        PH_PREFIX: begin
          if (prefix_pos <= PREFIX_LAST && char_in == pchar) begin
            prefix_pos_next = prefix_pos + 4'd1;
            if (prefix_pos == PREFIX_LAST) phase_next = PH_ITER;
          end else begin
            failed_next = 1'b1;
          end
        end
        PH_ITER: begin
          if (char_in inside {[8'h30:8'h39]}) begin
            if (digit_count >= MAX_DIGITS) begin
              failed_next = 1'b1;
            end else begin
              iter_accum_next = {iter_accum[ACCUM_W-4:0], 3'b000}
                              + {iter_accum[ACCUM_W-2:0], 1'b0}
                              + ACCUM_W'(char_in[3:0]);
              digit_count_next = digit_count + 4'd1;
            end
          end else if (char_in == FIELD_SEP) begin
            if (digit_count == '0 || iter_accum == '0 || iter_accum > MAX_ITER)
              failed_next = 1'b1;
            else
              phase_next = PH_SALT;
          end else begin
            failed_next = 1'b1;
          end
        end
        default: begin
          if (!hex_val[4]) begin
            if (nibble_pending) begin
              bvalid = 1'b1;
              bval   = {high_nibble, hex_val[3:0]};
              if (phase == PH_SALT) begin
                salt_nonempty_next = 1'b1;
              end else begin
                hash_nonempty_next = 1'b1;
                bfield             = 1'b1;
              end
              nibble_pending_next = 1'b0;
            end else begin
              high_nibble_next    = hex_val[3:0];
              nibble_pending_next = 1'b1;
            end
          end else if (char_in == FIELD_SEP && phase == PH_SALT && !nibble_pending
                       && salt_nonempty) begin
            phase_next = PH_HASH;
          end else begin
            failed_next = 1'b1;
          end
        end
      endcase
    end
  end

  assign ok = !failed_next && phase_next == PH_HASH && hash_nonempty_next
              && !nibble_pending_next;

  always_comb begin
    res             = '0;
    res.byte_valid  = bvalid;
    res.byte_value  = bval;
    res.byte_field  = bfield;
    if (is_last) begin
      res.done_res    = 1'b1;
      res.well_formed = ok;
      res.prefix_seen = phase_next != PH_PREFIX;
      res.iterations  = ok ? iter_accum_next[ITER_W-1:0] : '0;
    end
  end

  assign res_push = step && (bvalid || is_last);

  always_ff @(posedge clk) begin
    if (rst || (step && is_last)) begin
      phase          <= PH_PREFIX;
      prefix_pos     <= '0;
      digit_count    <= '0;
      iter_accum     <= '0;
      high_nibble    <= '0;
      nibble_pending <= 1'b0;
      salt_nonempty  <= 1'b0;
      hash_nonempty  <= 1'b0;
      failed         <= 1'b0;
    end else if (step) begin
      phase          <= phase_next;
      prefix_pos     <= prefix_pos_next;
      digit_count    <= digit_count_next;
      iter_accum     <= iter_accum_next;
      high_nibble    <= high_nibble_next;
      nibble_pending <= nibble_pending_next;
      salt_nonempty  <= salt_nonempty_next;
      hash_nonempty  <= hash_nonempty_next;
      failed         <= failed_next;
    end
  end

endmodule

@@ rtl/core/pbkdf_outq.sv @@
module pbkdf_outq
  import pbkdf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  pbkdf_res_t push_data,
  input  logic       pop,
  output logic       full,
  output logic       not_empty,
  output pbkdf_res_t head
);

  pbkdf_res_t mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full      = count == 2'd2;
  assign not_empty = count != 2'd0;
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule
